@@ src/cqs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cqs_pkg
// Types and constants shared by the keyed circular queue modules.
// ----------------------------------------------------------------------------
package cqs_pkg;

	localparam int DEFAULT_DEPTH         = 16;
	localparam int DEFAULT_PAYLOAD_WIDTH = 64;

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 32;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;
	localparam int STATUS_W = 3;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
	localparam int               CNT_MAX   = (2 ** CNT_W) - 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE  = 3'd0,
		CMD_DEQUEUE  = 3'd1,
		CMD_PEEK     = 3'd2,
		CMD_FIND_KEY = 3'd3,
		CMD_FIND_POS = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_RANGE     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCAN
	} state_t;

	// Word index of the capacity register in the APB space.
	localparam logic REG_CAPACITY = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    enq;
		logic    rd_head;
		logic    rd_pos;
		logic    scan_start;
		logic    scan_step;
		logic    pop;
		logic    res_ram;
		logic    res_zero;
		status_t res_status;
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic range_err;
		logic match;
		logic scan_last;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ src/cqs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cqs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/cqs_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cqs_regs
// APB register file holding the capacity register and deriving its clamped value.
// ----------------------------------------------------------------------------
module cqs_regs import cqs_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic                   cfg_clear,
	output logic      [CNT_W-1:0]  eff_cap
);

	localparam logic [CNT_W-1:0] DEPTH_CAP = (DEPTH > CNT_MAX) ? CNT_W'(CNT_MAX)
	                                                            : CNT_W'(DEPTH);

	logic [CNT_W-1:0] cap_q;
	logic             hit;

	assign hit       = (paddr[2] == REG_CAPACITY);
	assign cfg_clear = psel && penable && pwrite && hit;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_clear) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(APB_DW-CNT_W){1'b0}}, cap_q};
		end
	end

	// Zero acts as one slot; anything above the built depth acts as the depth.
	always_comb begin
		eff_cap = cap_q;
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_q > DEPTH_CAP) begin
			eff_cap = DEPTH_CAP;
		end
	end

endmodule
`default_nettype wire

@@ src/cqs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cqs_ctrl
// Command sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module cqs_ctrl import cqs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output logic          busy,
	output dp_ctrl_t      ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		ctrl.res_status = STS_OK;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (stat.cmd) inside
					CMD_ENQUEUE: begin
						if (stat.full) begin
							ctrl.res_zero   = 1'b1;
							ctrl.res_status = STS_FULL;
						end else begin
							ctrl.enq = 1'b1;
						end
					end
					CMD_DEQUEUE, CMD_PEEK: begin
						if (stat.empty) begin
							ctrl.res_zero   = 1'b1;
							ctrl.res_status = STS_EMPTY;
						end else begin
							ctrl.rd_head = 1'b1;
							state_d      = ST_READ;
						end
					end
					CMD_FIND_KEY: begin
						if (stat.empty) begin
							ctrl.res_zero   = 1'b1;
							ctrl.res_status = STS_NOT_FOUND;
						end else begin
							ctrl.scan_start = 1'b1;
							state_d         = ST_SCAN;
						end
					end
					CMD_FIND_POS: begin
						if (stat.range_err) begin
							ctrl.res_zero   = 1'b1;
							ctrl.res_status = STS_RANGE;
						end else begin
							ctrl.rd_pos = 1'b1;
							state_d     = ST_READ;
						end
					end
					default: begin
						ctrl.res_zero   = 1'b1;
						ctrl.res_status = STS_OK;
					end
				endcase
			end
			ST_READ: begin
				ctrl.res_ram = 1'b1;
				ctrl.pop     = (stat.cmd == CMD_DEQUEUE);
				state_d      = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.match) begin
					ctrl.res_ram = 1'b1;
					state_d      = ST_IDLE;
				end else if (stat.scan_last) begin
					ctrl.res_zero   = 1'b1;
					ctrl.res_status = STS_NOT_FOUND;
					state_d         = ST_IDLE;
				end else begin
					ctrl.scan_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/cqs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cqs_dp
// Queue datapath: ring pointers, occupancy, search walker and result registers.
// ----------------------------------------------------------------------------
module cqs_dp import cqs_pkg::*; #(
	parameter int DEPTH         = DEFAULT_DEPTH,
	parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dp_ctrl_t                 ctrl,
	output dp_stat_t                      stat,
	input  wire logic                     cfg_clear,
	input  wire logic [CNT_W-1:0]         eff_cap,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic [KEY_W-1:0]         entry_key,
	input  wire logic [PAYLOAD_WIDTH-1:0] entry_payload,
	input  wire logic [POS_W-1:0]         position,
	output logic                          ram_we,
	output logic      [$clog2(DEPTH)-1:0] ram_waddr,
	output logic      [KEY_W-1:0]         ram_wkey,
	output logic      [PAYLOAD_WIDTH-1:0] ram_wpayload,
	output logic      [$clog2(DEPTH)-1:0] ram_raddr,
	input  wire logic [KEY_W-1:0]         ram_rkey,
	input  wire logic [PAYLOAD_WIDTH-1:0] ram_rpayload,
	output logic                          done,
	output logic      [STATUS_W-1:0]      status,
	output logic      [KEY_W-1:0]         result_key,
	output logic      [PAYLOAD_WIDTH-1:0] result_payload,
	output logic      [POS_W-1:0]         found_position,
	output logic      [CNT_W-1:0]         occupancy
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s,
	                                               input logic [CNT_W-1:0] cap);
		logic [SUM_W-1:0] inc;
		inc = SUM_W'(s) + SUM_W'(1);
		return (inc >= SUM_W'(cap)) ? '0 : inc[IDX_W-1:0];
	endfunction

	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         tail_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         off_q;
	logic [IDX_W-1:0]         slot_q;
	logic                     done_q;
	cmd_t                     cmd_q;
	logic [KEY_W-1:0]         key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [POS_W-1:0]         pos_q;
	logic [STATUS_W-1:0]      status_q;
	logic [KEY_W-1:0]         rkey_q;
	logic [PAYLOAD_WIDTH-1:0] rpay_q;
	logic [POS_W-1:0]         fpos_q;
	logic [CNT_W-1:0]         occ_q;

	logic [SUM_W-1:0]         pos_sum;
	logic [IDX_W-1:0]         pos_slot;
	logic [POS_W-1:0]         ram_fpos;

	// Head plus an offset below the occupancy stays below twice the capacity.
	always_comb begin
		pos_sum = SUM_W'(head_q) + SUM_W'(pos_q);
		if (pos_sum >= SUM_W'(eff_cap)) begin
			pos_sum = pos_sum - SUM_W'(eff_cap);
		end
		pos_slot = pos_sum[IDX_W-1:0];
	end

	always_comb begin
		stat.cmd       = cmd_q;
		stat.full      = (count_q >= eff_cap);
		stat.empty     = (count_q == '0);
		stat.range_err = (CNT_W'(pos_q) >= count_q);
		stat.match     = (ram_rkey == key_q);
		stat.scan_last = ((off_q + CNT_W'(1)) == count_q);
	end

	assign ram_we       = ctrl.enq;
	assign ram_waddr    = tail_q;
	assign ram_wkey     = key_q;
	assign ram_wpayload = pay_q;

	always_comb begin
		ram_raddr = slot_q;
		if (ctrl.rd_head || ctrl.scan_start) begin
			ram_raddr = head_q;
		end else if (ctrl.rd_pos) begin
			ram_raddr = pos_slot;
		end
	end

	always_comb begin
		case (cmd_q)
			CMD_FIND_POS: ram_fpos = pos_q;
			CMD_FIND_KEY: ram_fpos = off_q[POS_W-1:0];
			default:      ram_fpos = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			off_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctrl.enq || ctrl.res_ram || ctrl.res_zero;
			if (cfg_clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (ctrl.enq) begin
				tail_q  <= next_slot(tail_q, eff_cap);
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				head_q  <= next_slot(head_q, eff_cap);
				count_q <= count_q - CNT_W'(1);
			end
			if (ctrl.scan_start) begin
				off_q <= '0;
			end else if (ctrl.scan_step) begin
				off_q <= off_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd_t'(command);
			key_q <= entry_key;
			pay_q <= entry_payload;
			pos_q <= position;
		end
		if (ctrl.scan_start) begin
			slot_q <= next_slot(head_q, eff_cap);
		end else if (ctrl.scan_step) begin
			slot_q <= next_slot(slot_q, eff_cap);
		end
		if (ctrl.enq) begin
			status_q <= STS_OK;
			rkey_q   <= key_q;
			rpay_q   <= pay_q;
			fpos_q   <= count_q[POS_W-1:0];
			occ_q    <= count_q + CNT_W'(1);
		end else if (ctrl.res_ram) begin
			status_q <= STS_OK;
			rkey_q   <= ram_rkey;
			rpay_q   <= ram_rpayload;
			fpos_q   <= ram_fpos;
			occ_q    <= ctrl.pop ? (count_q - CNT_W'(1)) : count_q;
		end else if (ctrl.res_zero) begin
			status_q <= ctrl.res_status;
			rkey_q   <= '0;
			rpay_q   <= '0;
			fpos_q   <= '0;
			occ_q    <= count_q;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_key     = rkey_q;
	assign result_payload = rpay_q;
	assign found_position = fpos_q;
	assign occupancy      = occ_q;

endmodule
`default_nettype wire

@@ src/circular_queue_with_search_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_with_search_top
// Ring-buffer queue of keyed entries with enqueue, dequeue, peek, key search
// and positional read, a capacity register on APB and key/payload RAMs.
// ----------------------------------------------------------------------------
// Enqueue and error results are decided in the execute state; dequeue, peek
// and find by position add one registered RAM read; a key search then reads
// one stored entry per cycle until a key matches or all occupied entries are
// read. A new item may start while done is high.
// Reset empties the queue and sets the capacity to 16; RAM contents are not
// cleared. The receiver cannot stall; each result is shown for one cycle.
module circular_queue_with_search_top import cqs_pkg::*; #(
	parameter int DEPTH         = DEFAULT_DEPTH,
	parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_AW-1:0]        paddr,
	input  wire logic [APB_DW-1:0]        pwdata,
	output logic      [APB_DW-1:0]        prdata,
	output logic                          pready,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic [KEY_W-1:0]         entry_key,
	input  wire logic [PAYLOAD_WIDTH-1:0] entry_payload,
	input  wire logic [POS_W-1:0]         position,
	output logic                          done,
	output logic      [STATUS_W-1:0]      status,
	output logic      [KEY_W-1:0]         result_key,
	output logic      [PAYLOAD_WIDTH-1:0] result_payload,
	output logic      [POS_W-1:0]         found_position,
	output logic      [CNT_W-1:0]         occupancy
);

	localparam int IDX_W = $clog2(DEPTH);

	dp_ctrl_t                 ctrl;
	dp_stat_t                 stat;
	logic                     cfg_clear;
	logic [CNT_W-1:0]         eff_cap;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [IDX_W-1:0]         ram_raddr;
	logic [KEY_W-1:0]         ram_wkey;
	logic [KEY_W-1:0]         ram_rkey;
	logic [PAYLOAD_WIDTH-1:0] ram_wpayload;
	logic [PAYLOAD_WIDTH-1:0] ram_rpayload;

	cqs_regs #(
		.DEPTH(DEPTH)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg_clear(cfg_clear),
		.eff_cap  (eff_cap)
	);

	cqs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.ctrl  (ctrl)
	);

	cqs_dp #(
		.DEPTH        (DEPTH),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.cfg_clear     (cfg_clear),
		.eff_cap       (eff_cap),
		.command       (command),
		.entry_key     (entry_key),
		.entry_payload (entry_payload),
		.position      (position),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wkey      (ram_wkey),
		.ram_wpayload  (ram_wpayload),
		.ram_raddr     (ram_raddr),
		.ram_rkey      (ram_rkey),
		.ram_rpayload  (ram_rpayload),
		.done          (done),
		.status        (status),
		.result_key    (result_key),
		.result_payload(result_payload),
		.found_position(found_position),
		.occupancy     (occupancy)
	);

	cqs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wkey),
		.raddr(ram_raddr),
		.rdata(ram_rkey)
	);

	cqs_ram #(
		.WIDTH(PAYLOAD_WIDTH),
		.DEPTH(DEPTH)
	) u_payload_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wpayload),
		.raddr(ram_raddr),
		.rdata(ram_rpayload)
	);

endmodule
`default_nettype wire

@@ bench/circular_queue_with_search_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_search_top_test
// Self-checking bench for the keyed circular queue. A directed table covers
// empty and full queues, unused command codes, key and position misses and
// capacity writes. Random phases then run at several capacities, including
// out-of-range register values. Results are checked against table values or a
// cycle-free model of the queue kept in the bench.
// ----------------------------------------------------------------------------
module circular_queue_with_search_top_test import cqs_pkg::*; ();

	localparam int     DEPTH           = DEFAULT_DEPTH;
	localparam int     PAY_W           = DEFAULT_PAYLOAD_WIDTH;
	localparam int     ITEMS_PER_PHASE = 200;
	localparam int     NUM_PHASES      = 8;
	localparam int     RANDOM_CAP_PHASE = 6;
	localparam int     KEY_POOL_SIZE   = 8;
	localparam int     SETTLE_CYCLES   = 24;
	localparam int     MAX_REPORTS     = 10;
	localparam int     DIRECTED_ROWS   = 28;
	localparam longint TIMEOUT_NS      = 64'd5_000_000;

	// Command codes the block does not define; they must leave the queue alone.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

	localparam logic [CNT_W-1:0] PHASE_CAPACITY [NUM_PHASES] =
		'{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd16, 5'd16};

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic [POS_W-1:0]   fpos;
		logic [CNT_W-1:0]   occupancy;
	} queue_result_t;

	typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_t;

	// A capacity row carries the register value in its key field.
	typedef struct packed {
		row_kind_t          kind;
		logic [CMD_W-1:0]   cmd;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic [POS_W-1:0]   pos;
		logic               typed;
		queue_result_t      expected;
	} stim_row_t;

	localparam queue_result_t NO_CHECK = '0;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_ITEM, CMD_DEQUEUE, 32'h0, 64'h0, 4'd0, 1'b1,
			'{STS_EMPTY, 32'h0, 64'h0, 4'd0, 5'd0}},
		'{ROW_ITEM, CMD_PEEK, 32'h0, 64'h0, 4'd0, 1'b1,
			'{STS_EMPTY, 32'h0, 64'h0, 4'd0, 5'd0}},
		'{ROW_ITEM, CMD_FIND_KEY, 32'h0, 64'h0, 4'd0, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 64'h0, 4'd0, 5'd0}},
		'{ROW_ITEM, CMD_FIND_POS, 32'h0, 64'h0, 4'd0, 1'b1,
			'{STS_RANGE, 32'h0, 64'h0, 4'd0, 5'd0}},
		'{ROW_ITEM, CMD_SPARE_HI, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1,
			'{STS_OK, 32'h0, 64'h0, 4'd0, 5'd0}},
		'{ROW_ITEM, CMD_ENQUEUE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1,
			'{STS_OK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 5'd1}},
		'{ROW_ITEM, CMD_ENQUEUE, 32'h0, 64'h0, 4'd15, 1'b1,
			'{STS_OK, 32'h0, 64'h0, 4'd1, 5'd2}},
		'{ROW_ITEM, CMD_ENQUEUE, 32'hA5A5_A5A5, 64'h5A5A_5A5A_C3C3_C3C3, 4'd9, 1'b1,
			'{STS_OK, 32'hA5A5_A5A5, 64'h5A5A_5A5A_C3C3_C3C3, 4'd2, 5'd3}},
		'{ROW_ITEM, CMD_FIND_KEY, 32'h0, 64'h1234, 4'd7, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_FIND_KEY, 32'h1234_5678, 64'h0, 4'd0, 1'b1,
			'{STS_NOT_FOUND, 32'h0, 64'h0, 4'd0, 5'd3}},
		'{ROW_ITEM, CMD_FIND_POS, 32'h0, 64'h0, 4'd2, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_FIND_POS, 32'h0, 64'h0, 4'd15, 1'b1,
			'{STS_RANGE, 32'h0, 64'h0, 4'd0, 5'd3}},
		'{ROW_ITEM, CMD_FIND_POS, 32'h0, 64'h0, 4'd3, 1'b1,
			'{STS_RANGE, 32'h0, 64'h0, 4'd0, 5'd3}},
		'{ROW_ITEM, CMD_PEEK, 32'h0, 64'h0, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_DEQUEUE, 32'h0, 64'h0, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_SPARE_LO, 32'h0, 64'h0, 4'd0, 1'b1,
			'{STS_OK, 32'h0, 64'h0, 4'd0, 5'd2}},
		'{ROW_ITEM, CMD_SPARE_MID, 32'h0, 64'h0, 4'd0, 1'b1,
			'{STS_OK, 32'h0, 64'h0, 4'd0, 5'd2}},
		'{ROW_CAPACITY, CMD_ENQUEUE, 32'd2, 64'h0, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_ENQUEUE, 32'd1, 64'h11, 4'd0, 1'b1,
			'{STS_OK, 32'd1, 64'h11, 4'd0, 5'd1}},
		'{ROW_ITEM, CMD_ENQUEUE, 32'd2, 64'h22, 4'd0, 1'b1,
			'{STS_OK, 32'd2, 64'h22, 4'd1, 5'd2}},
		'{ROW_ITEM, CMD_ENQUEUE, 32'd3, 64'h33, 4'd0, 1'b1,
			'{STS_FULL, 32'h0, 64'h0, 4'd0, 5'd2}},
		'{ROW_ITEM, CMD_DEQUEUE, 32'h0, 64'h0, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_ENQUEUE, 32'd4, 64'h44, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_FIND_KEY, 32'd4, 64'h0, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_FIND_POS, 32'h0, 64'h0, 4'd1, 1'b0, NO_CHECK},
		'{ROW_CAPACITY, CMD_ENQUEUE, 32'd0, 64'h0, 4'd0, 1'b0, NO_CHECK},
		'{ROW_ITEM, CMD_ENQUEUE, 32'd5, 64'h55, 4'd0, 1'b1,
			'{STS_OK, 32'd5, 64'h55, 4'd0, 5'd1}},
		'{ROW_ITEM, CMD_ENQUEUE, 32'd6, 64'h66, 4'd0, 1'b1,
			'{STS_FULL, 32'h0, 64'h0, 4'd0, 5'd1}}
	};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [APB_AW-1:0]   paddr         = '0;
	logic [APB_DW-1:0]   pwdata        = '0;
	logic                start         = 1'b0;
	logic [CMD_W-1:0]    command       = '0;
	logic [KEY_W-1:0]    entry_key     = '0;
	logic [PAY_W-1:0]    entry_payload = '0;
	logic [POS_W-1:0]    position      = '0;
	wire  [APB_DW-1:0]   prdata;
	wire                 pready;
	wire                 busy;
	wire                 done;
	wire  [STATUS_W-1:0] status;
	wire  [KEY_W-1:0]    result_key;
	wire  [PAY_W-1:0]    result_payload;
	wire  [POS_W-1:0]    found_position;
	wire  [CNT_W-1:0]    occupancy;

	queue_result_t pending_results[$];
	int            mismatch_count = 0;
	int            result_count   = 0;

	// Bench copy of the queue.
	logic [KEY_W-1:0]    key_mem [DEPTH];
	logic [PAY_W-1:0]    pay_mem [DEPTH];
	int                  ring_head    = 0;
	int                  ring_tail    = 0;
	int                  entry_count  = 0;
	logic [CNT_W-1:0]    capacity_reg = CAP_RESET;

	// Zero behaves as one slot and anything above the built depth as the depth.
	function automatic int live_capacity();
		int c;
		c = int'(capacity_reg);
		if (c == 0)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		return c;
	endfunction

	function automatic int ring_slot(input int offset, input int cap);
		int s;
		s = ring_head + offset;
		while (s >= cap)
			s -= cap;
		return s;
	endfunction

	function automatic queue_result_t apply_queue_command(
		input logic [CMD_W-1:0] cmd,
		input logic [KEY_W-1:0] key,
		input logic [PAY_W-1:0] pay,
		input logic [POS_W-1:0] pos
	);
		queue_result_t r;
		int            cap;
		int            slot;
		r = '0;
		r.status = STS_OK;
		cap = live_capacity();
		case (cmd)
			CMD_ENQUEUE: begin
				if (entry_count >= cap) begin
					r.status = STS_FULL;
				end else begin
					key_mem[ring_tail] = key;
					pay_mem[ring_tail] = pay;
					ring_tail = (ring_tail + 1 >= cap) ? 0 : ring_tail + 1;
					r.fpos = POS_W'(entry_count);
					entry_count++;
					r.key = key;
					r.payload = pay;
				end
			end
			CMD_DEQUEUE, CMD_PEEK: begin
				if (entry_count == 0) begin
					r.status = STS_EMPTY;
				end else begin
					r.key = key_mem[ring_head];
					r.payload = pay_mem[ring_head];
					if (cmd == CMD_DEQUEUE) begin
						ring_head = (ring_head + 1 >= cap) ? 0 : ring_head + 1;
						entry_count--;
					end
				end
			end
			CMD_FIND_KEY: begin
				// The first match in queue order wins.
				r.status = STS_NOT_FOUND;
				for (int i = 0; i < entry_count; i++) begin
					slot = ring_slot(i, cap);
					if (r.status == STS_NOT_FOUND && key_mem[slot] == key) begin
						r.status = STS_OK;
						r.key = key_mem[slot];
						r.payload = pay_mem[slot];
						r.fpos = POS_W'(i);
					end
				end
			end
			CMD_FIND_POS: begin
				if (int'(pos) >= entry_count) begin
					r.status = STS_RANGE;
				end else begin
					slot = ring_slot(int'(pos), cap);
					r.key = key_mem[slot];
					r.payload = pay_mem[slot];
					r.fpos = pos;
				end
			end
			default: begin
			end
		endcase
		r.occupancy = CNT_W'(entry_count);
		return r;
	endfunction

	task automatic send_item(
		input logic [CMD_W-1:0] cmd,
		input logic [KEY_W-1:0] key,
		input logic [PAY_W-1:0] pay,
		input logic [POS_W-1:0] pos,
		input bit               idle_on,
		input bit               use_typed,
		input queue_result_t    typed_result
	);
		queue_result_t predicted;
		if (idle_on && $urandom_range(99) < 24) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start         <= 1'b1;
		command       <= cmd;
		entry_key     <= key;
		entry_payload <= pay;
		position      <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_queue_command(cmd, key, pay, pos);
		pending_results.push_back(use_typed ? typed_result : predicted);
	endtask

	// Holds off new items until every outstanding result is back.
	task automatic wait_until_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CAPACITY, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// Any capacity write empties the queue.
		capacity_reg = value[CNT_W-1:0];
		ring_head    = 0;
		ring_tail    = 0;
		entry_count  = 0;
	endtask

	circular_queue_with_search_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.entry_key      (entry_key),
		.entry_payload  (entry_payload),
		.position       (position),
		.done           (done),
		.status         (status),
		.result_key     (result_key),
		.result_payload (result_payload),
		.found_position (found_position),
		.occupancy      (occupancy)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("ERROR: result %0d arrived with no item outstanding", result_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || result_key !== want.key ||
						result_payload !== want.payload || found_position !== want.fpos ||
						occupancy !== want.occupancy) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("ERROR: result %0d expected sts %0d key %h pay %h pos %0d occ %0d",
							result_count, want.status, want.key, want.payload, want.fpos,
							want.occupancy);
						$display("       got                sts %0d key %h pay %h pos %0d occ %0d",
							status, result_key, result_payload, found_position, occupancy);
					end
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		stim_row_t          row;
		logic [CMD_W-1:0]   cmd;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   pay;
		logic [POS_W-1:0]   pos;
		logic [APB_DW-1:0]  cap_word;
		logic [KEY_W-1:0]   key_pool [KEY_POOL_SIZE];
		int                 pick;
		int                 sel;
		int                 cap_now;
		bit                 filling;
		bit                 idle_on;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CAPACITY) begin
				wait_until_drained();
				write_capacity(row.key);
			end else begin
				send_item(row.cmd, row.key, row.payload, row.pos, 1'b0, row.typed,
					row.expected);
			end
		end

		filling = 1'b1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_until_drained();
			cap_word = $urandom;
			cap_word[CNT_W-1:0] = (phase == RANDOM_CAP_PHASE) ?
				CNT_W'($urandom_range(31)) : PHASE_CAPACITY[phase];
			write_capacity(cap_word);

			// A small pool of keys makes repeats and search hits common.
			foreach (key_pool[k])
				key_pool[k] = $urandom;
			key_pool[0] = '0;
			key_pool[1] = '1;
			// The first phase runs back to back with no idle cycles.
			idle_on = (phase != 0);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 3 && n == ITEMS_PER_PHASE / 2)
					wait_until_drained();
				cap_now = live_capacity();
				if (entry_count >= cap_now)
					filling = 1'b0;
				else if (entry_count == 0)
					filling = 1'b1;
				else if ($urandom_range(99) < 3)
					filling = !filling;

				key = $urandom;
				pay = {$urandom, $urandom};
				pos = POS_W'($urandom_range(15));
				pick = $urandom_range(99);
				if (pick < 3)
					cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
				else if (pick < (filling ? 48 : 13))
					cmd = CMD_ENQUEUE;
				else if (pick < 58)
					cmd = CMD_DEQUEUE;
				else if (pick < 68)
					cmd = CMD_PEEK;
				else if (pick < 84)
					cmd = CMD_FIND_KEY;
				else
					cmd = CMD_FIND_POS;

				case (cmd)
					CMD_ENQUEUE: begin
						if ($urandom_range(99) < 70)
							key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
						if ($urandom_range(99) < 5)
							pay = $urandom_range(1) ? '1 : '0;
					end
					CMD_FIND_KEY: begin
						sel = $urandom_range(99);
						if (entry_count > 0 && sel < 50)
							key = key_mem[ring_slot($urandom_range(entry_count - 1), cap_now)];
						else if (sel < 80)
							key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
					end
					CMD_FIND_POS: begin
						if (entry_count > 0 && $urandom_range(99) < 60)
							pos = POS_W'($urandom_range(entry_count - 1));
					end
					default: begin
					end
				endcase
				send_item(cmd, key, pay, pos, idle_on, 1'b0, NO_CHECK);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
src/cqs_pkg.sv
src/cqs_ram.sv
src/cqs_regs.sv
src/cqs_ctrl.sv
src/cqs_dp.sv
src/circular_queue_with_search_top.sv
bench/circular_queue_with_search_top_test.sv
